@@ rtl/urrb_pkg.sv @@
// Shared types and codes for the multi-channel receive ring buffers.
package urrb_pkg;

  localparam int CNT_W = 7;

  localparam logic [1:0] MODE_RX    = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [1:0]       channel;
    logic [7:0]       rx_byte;
    logic [CNT_W-1:0] read_limit;
  } in_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             byte_valid;
    logic [CNT_W-1:0] read_count;
    logic             last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_BURST = 3'b010,
    ST_EMPTY = 3'b100
  } state_t;

endpackage

@@ rtl/urrb_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module urrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data when no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/uart_rx_ring_buffers_core.sv @@
// Top level of the multi-channel receive ring buffers: pointer table, burst sequencer, output.
//
// One receive ring per serial channel, all rings in one shared byte RAM
// addressed as channel * DEPTH + index. Per channel a write index, a read
// index and a wrapped flag live in flops next to the RAM.
// Input channel (in_valid/in_ready/in_data) carries one command per beat:
// receive a byte, read a burst, or clear a channel.
// Receive and clear leave in_ready high.
// A read burst answers with 1 to MAX_READ-1 result beats on the out_ channel,
// the final one flagged last and carrying the count. The first byte passes from the
// command beat through the burst state and the RAM read data into the output
// register; after that one byte per cycle while out_ready stays high, set by
// the single RAM read port. A burst that copies nothing gives one empty result.
// in_ready stays low while a burst walks the ring and while a fetched byte
// waits for the output register; a finished result may still sit in the
// output register while the next command is taken.
// When the receiver stalls, the output register holds its beat, the RAM read
// data is held, and the walk pauses; nothing is dropped.
// Reset clears all indices and flags at once. The RAM is not cleared and
// needs no clearing pass: only entries written since are ever read back.
module uart_rx_ring_buffers_core #(
  parameter int DEPTH        = 128,
  parameter int NUM_CHANNELS = 4,
  parameter int MAX_READ     = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  urrb_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output urrb_pkg::out_t out_data
);

  localparam int IW     = $clog2(DEPTH);
  localparam int CHW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ADDR_W = $clog2(NUM_CHANNELS * DEPTH);
  localparam int CW     = urrb_pkg::CNT_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  // Per-channel pointer table.
  logic [IW-1:0] wr_idx_r [NUM_CHANNELS];
  logic [IW-1:0] rd_idx_r [NUM_CHANNELS];
  logic          wrap_r   [NUM_CHANNELS];

  // Burst sequencer.
  urrb_pkg::state_t state_r;
  logic [CHW-1:0]   ch_r;
  logic [IW-1:0]    rp_r;
  logic [IW-1:0]    wp_r;
  logic [CW-1:0]    lim_r;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    empty_cnt_r;

  // Fetched byte waiting in RAM read data.
  logic          pend_r;
  logic          pend_last_r;
  logic [CW-1:0] pend_cnt_r;

  logic           out_valid_r;
  urrb_pkg::out_t out_r;

  // Command decode.
  logic              in_fire;
  logic              ch_ok;
  logic [CHW+1:0]    ch_wide;
  logic [CHW-1:0]    ch_idx;
  logic [IW-1:0]     cur_w;
  logic [IW-1:0]     cur_r;
  logic              cur_wrap;
  logic              cur_full_wrap;
  logic [IW-1:0]     base_w;
  logic              base_at_end;
  logic [CW-1:0]     lim_sat;
  logic              rx_go;

  // Burst step.
  logic              out_free;
  logic              issue;
  logic              load_byte;
  logic              load_empty;
  logic [CW-1:0]     step_cnt;
  logic [CW:0]       step_cnt_p1;
  logic [IW-1:0]     rp_adv;
  logic              end_walk;
  logic              end_lim;
  logic              step_last;

  // RAM ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_q;

  assign in_ready = (state_r == urrb_pkg::ST_IDLE) && !pend_r;
  assign in_fire  = in_valid && in_ready;

  assign ch_ok   = int'(in_data.channel) < NUM_CHANNELS;
  assign ch_wide = {CHW'(0), in_data.channel};
  assign ch_idx  = ch_ok ? ch_wide[CHW-1:0] : '0;

  assign cur_w    = wr_idx_r[ch_idx];
  assign cur_r    = rd_idx_r[ch_idx];
  assign cur_wrap = wrap_r[ch_idx];

  // A full ring that gets another byte drops its contents and starts over with that byte.
  assign cur_full_wrap = cur_wrap && (cur_w == cur_r);
  assign base_w        = cur_full_wrap ? '0 : cur_w;
  assign base_at_end   = (base_w == LAST_IDX);

  assign lim_sat = (in_data.read_limit > CW'(MAX_READ)) ? CW'(MAX_READ) : in_data.read_limit;

  assign rx_go = in_fire && ch_ok && (in_data.mode == urrb_pkg::MODE_RX);

  assign ram_we    = rx_go;
  assign ram_waddr = ADDR_W'(ch_idx) * ADDR_W'(DEPTH) + ADDR_W'(base_w);

  // Issue a read only when no fetched byte is pending or the pending one can move on.
  assign out_free = !out_valid_r || out_ready;
  assign issue    = (state_r == urrb_pkg::ST_BURST) && (!pend_r || out_free);
  assign load_byte  = pend_r && out_free;
  assign load_empty = (state_r == urrb_pkg::ST_EMPTY) && !pend_r && out_free;

  assign ram_raddr = ADDR_W'(ch_r) * ADDR_W'(DEPTH) + ADDR_W'(rp_r);

  // The byte at rp_r takes count step_cnt; it ends the burst when the walk
  // meets the write index or the next count would reach the limit.
  assign step_cnt    = cnt_r + CW'(1);
  assign step_cnt_p1 = {1'b0, step_cnt} + (CW+1)'(1);
  assign rp_adv      = (rp_r == LAST_IDX) ? '0 : rp_r + IW'(1);
  assign end_walk    = (rp_adv == wp_r);
  assign end_lim     = step_cnt_p1 >= {1'b0, lim_r};
  assign step_last   = end_walk || end_lim;

  urrb_ram #(
    .WIDTH (8),
    .DEPTH (NUM_CHANNELS * DEPTH)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.rx_byte),
    .re    (issue),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Pointer table and sequencer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        wr_idx_r[i] <= '0;
        rd_idx_r[i] <= '0;
        wrap_r[i]   <= 1'b0;
      end
      state_r <= urrb_pkg::ST_IDLE;
      pend_r  <= 1'b0;
    end else begin
      if (in_fire && ch_ok) begin
        case (in_data.mode)
          urrb_pkg::MODE_RX: begin
            wr_idx_r[ch_idx] <= base_at_end ? '0 : base_w + IW'(1);
            rd_idx_r[ch_idx] <= cur_full_wrap ? '0 : cur_r;
            wrap_r[ch_idx]   <= base_at_end || (cur_wrap && !cur_full_wrap);
          end
          urrb_pkg::MODE_READ: begin
            // Leftovers past the limit are dropped.
            rd_idx_r[ch_idx] <= cur_w;
          end
          urrb_pkg::MODE_CLEAR: begin
            wr_idx_r[ch_idx] <= '0;
            rd_idx_r[ch_idx] <= '0;
            wrap_r[ch_idx]   <= 1'b0;
          end
          default: begin
          end
        endcase
      end

      if (issue && (rp_r == LAST_IDX)) begin
        wrap_r[ch_r] <= 1'b0;
      end

      case (state_r)
        urrb_pkg::ST_IDLE: begin
          if (in_fire && (in_data.mode == urrb_pkg::MODE_READ)) begin
            if (ch_ok && (cur_r != cur_w) && (lim_sat > CW'(1))) begin
              state_r <= urrb_pkg::ST_BURST;
            end else begin
              state_r <= urrb_pkg::ST_EMPTY;
            end
          end
        end
        urrb_pkg::ST_BURST: begin
          if (issue && step_last) begin
            state_r <= urrb_pkg::ST_IDLE;
          end
        end
        urrb_pkg::ST_EMPTY: begin
          if (load_empty) begin
            state_r <= urrb_pkg::ST_IDLE;
          end
        end
        default: begin
          state_r <= urrb_pkg::ST_IDLE;
        end
      endcase

      if (issue) begin
        pend_r <= 1'b1;
      end else if (load_byte) begin
        pend_r <= 1'b0;
      end
    end
  end

  // Burst payload registers.
  always_ff @(posedge clk) begin
    if (in_fire && (in_data.mode == urrb_pkg::MODE_READ)) begin
      ch_r        <= ch_idx;
      rp_r        <= cur_r;
      wp_r        <= cur_w;
      lim_r       <= lim_sat;
      cnt_r       <= '0;
      empty_cnt_r <= (ch_ok && (cur_r != cur_w)) ? CW'(1) : '0;
    end else if (issue) begin
      rp_r        <= rp_adv;
      cnt_r       <= step_cnt;
      pend_last_r <= step_last;
      pend_cnt_r  <= end_walk ? step_cnt : step_cnt_p1[CW-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_byte || load_empty) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_byte) begin
      out_r.data_byte  <= ram_q;
      out_r.byte_valid <= 1'b1;
      out_r.read_count <= pend_last_r ? pend_cnt_r : '0;
      out_r.last       <= pend_last_r;
    end else if (load_empty) begin
      out_r.data_byte  <= '0;
      out_r.byte_valid <= 1'b0;
      out_r.read_count <= empty_cnt_r;
      out_r.last       <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // RAM reads come only from a walking burst.
  a_read_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (state_r == urrb_pkg::ST_BURST))
    else $error("RAM read issued outside a burst");

  // A walking burst has always a byte left and stays under the limit.
  a_burst_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == urrb_pkg::ST_BURST) |->
      ((rp_r != wp_r) && (({1'b0, cnt_r} + (CW+1)'(1)) < {1'b0, lim_r})))
    else $error("burst walked past its end or limit");

  // A fetched byte held back by a stall keeps its read data.
  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && out_valid_r && !out_ready) |=> (pend_r && $stable(ram_q)))
    else $error("fetched byte lost during stall");

  // An empty result closes its burst and carries no byte.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.byte_valid) |-> (out_r.last && (out_r.data_byte == 8'd0)))
    else $error("malformed empty result");

  // No new command while a burst still owns the RAM read data.
  a_no_cmd_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (!pend_r && (state_r == urrb_pkg::ST_IDLE)))
    else $error("command taken during a burst");

endmodule
